[src/wrlav_pkg.sv]
// shared types and constants of the scanline run-length mean block
`default_nettype none
package wrlav_pkg;

	localparam int LEVEL_W = 16;
	localparam int RUN_W   = 13;
	localparam int SUM_W   = 32;
	localparam int TOTAL_W = 24;
	localparam int WSUM_W  = 24;

	// brightness weights and divisor
	localparam logic [WSUM_W-1:0] WEIGHT_RED   = 24'd60;
	localparam logic [WSUM_W-1:0] WEIGHT_GREEN = 24'd118;
	localparam logic [WSUM_W-1:0] WEIGHT_BLUE  = 24'd22;

	// x / 200 = ((x >> 3) * DIV25_MUL) >> DIV25_SHIFT, exact for x < 2^24
	localparam int DIV_PRE_SHIFT = 3;
	localparam int DIV25_SHIFT   = 26;
	localparam logic [21:0] DIV25_MUL = 22'd2684355;

	localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

	typedef enum logic [1:0] {
		REG_LEVEL_LOW  = 2'd0,
		REG_LEVEL_HIGH = 2'd1,
		REG_MIN_RUN    = 2'd2,
		REG_COLOR_MODE = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] level_low;
		logic [LEVEL_W-1:0] level_high;
		logic [RUN_W-1:0]   min_run;
		logic               color_mode;
	} cfg_t;

	typedef struct packed {
		logic [15:0] plane_red;
		logic [15:0] plane_green;
		logic [15:0] plane_blue;
		logic        row_first;
		logic        frame_last;
	} pix_t;

	typedef struct packed {
		logic [RUN_W-1:0]   mean_size;
		logic [TOTAL_W-1:0] runs_counted;
		logic               no_runs;
	} res_t;

	typedef struct packed {
		logic [SUM_W-1:0]   length_sum;
		logic [TOTAL_W-1:0] run_total;
	} frame_tot_t;

	typedef struct packed {
		logic push;
		logic pop;
		logic empty;
		logic full;
	} q_ctl_t;

endpackage
`default_nettype wire

[src/wrlav_stream_if.sv]
// valid/ready stream interface carrying one request payload
`default_nettype none
interface wrlav_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[src/wrlav_front.sv]
// front end: brightness, window test, run tracking and per-frame totals
`default_nettype none
module wrlav_front #(
	parameter int MAX_ROW_WIDTH = 4096
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wrlav_pkg::cfg_t          cfg,
	wrlav_stream_if.sink             pix,
	input  wire                      q_full,
	output logic                     q_push,
	output wrlav_pkg::frame_tot_t    q_wdata
);
	import wrlav_pkg::*;

	localparam int CAP_INT = (MAX_ROW_WIDTH < 8191) ? MAX_ROW_WIDTH : 8191;
	localparam logic [RUN_W-1:0] RUN_CAP = RUN_W'(CAP_INT);

	logic               adv;
	logic               v_s1, v_s2;
	logic [WSUM_W-1:0]  val_s1;
	logic               first_s1, last_s1, first_s2, last_s2;
	logic [LEVEL_W-1:0] level_s2;

	logic               inside_q;
	logic [RUN_W-1:0]   len_q;
	logic [SUM_W-1:0]   sum_q;
	logic [TOTAL_W-1:0] total_q;

	logic [WSUM_W-DIV_PRE_SHIFT-1:0] pre;
	logic [WSUM_W-DIV_PRE_SHIFT+22-1:0] prod;
	logic [LEVEL_W-1:0] level_d;
	logic               obj, end_run, acc_ok;
	logic [SUM_W:0]     sum_add;
	logic [RUN_W-1:0]   len_n;
	logic [SUM_W-1:0]   sum_n;
	logic [TOTAL_W-1:0] total_n;

	assign adv       = !(v_s2 && last_s2 && q_full);
	assign pix.ready = adv;

	always_comb begin
		pre     = val_s1[WSUM_W-1:DIV_PRE_SHIFT];
		prod    = (WSUM_W-DIV_PRE_SHIFT+22)'(pre) * (WSUM_W-DIV_PRE_SHIFT+22)'(DIV25_MUL);
		level_d = cfg.color_mode ? prod[DIV25_SHIFT +: LEVEL_W] : val_s1[LEVEL_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= pix.valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (cfg.color_mode) begin
				val_s1 <= WSUM_W'(pix.data.plane_red) * WEIGHT_RED
					+ WSUM_W'(pix.data.plane_green) * WEIGHT_GREEN
					+ WSUM_W'(pix.data.plane_blue) * WEIGHT_BLUE;
			end else begin
				val_s1 <= WSUM_W'(pix.data.plane_red);
			end
			first_s1 <= pix.data.row_first;
			last_s1  <= pix.data.frame_last;
			level_s2 <= level_d;
			first_s2 <= first_s1;
			last_s2  <= last_s1;
		end
	end

	always_comb begin
		obj     = (level_s2 >= cfg.level_low) && (level_s2 <= cfg.level_high);
		end_run = !obj && !first_s2 && inside_q && (len_q >= cfg.min_run);
		sum_add = {1'b0, sum_q} + (SUM_W+1)'(len_q);
		acc_ok  = (total_q != TOTAL_MAX) && !sum_add[SUM_W];
		if (obj) begin
			if (first_s2 || !inside_q) begin
				len_n = RUN_W'(1);
			end else if (len_q < RUN_CAP) begin
				len_n = len_q + RUN_W'(1);
			end else begin
				len_n = len_q;
			end
		end else begin
			len_n = '0;
		end
		if (end_run && acc_ok) begin
			sum_n   = sum_add[SUM_W-1:0];
			total_n = total_q + TOTAL_W'(1);
		end else begin
			sum_n   = sum_q;
			total_n = total_q;
		end
		q_push             = adv && v_s2 && last_s2;
		q_wdata.length_sum = sum_n;
		q_wdata.run_total  = total_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q <= 1'b0;
			len_q    <= '0;
			sum_q    <= '0;
			total_q  <= '0;
		end else if (adv && v_s2) begin
			if (last_s2) begin
				inside_q <= 1'b0;
				len_q    <= '0;
				sum_q    <= '0;
				total_q  <= '0;
			end else begin
				inside_q <= obj;
				len_q    <= len_n;
				sum_q    <= sum_n;
				total_q  <= total_n;
			end
		end
	end
endmodule
`default_nettype wire

[src/wrlav_fifo.sv]
// two-entry queue of frame totals between front and back
`default_nettype none
module wrlav_fifo (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wrlav_pkg::q_ctl_t        ctl_in,
	input  wrlav_pkg::frame_tot_t    wdata,
	output wrlav_pkg::q_ctl_t        ctl_out,
	output wrlav_pkg::frame_tot_t    rdata
);
	import wrlav_pkg::*;

	frame_tot_t  mem_q [2];
	logic        wr_ptr_q, rd_ptr_q;
	logic [1:0]  cnt_q;
	logic        do_push, do_pop;

	assign do_push = ctl_in.push && (cnt_q != 2'd2);
	assign do_pop  = ctl_in.pop && (cnt_q != 2'd0);

	always_comb begin
		ctl_out.push  = do_push;
		ctl_out.pop   = do_pop;
		ctl_out.empty = (cnt_q == 2'd0);
		ctl_out.full  = (cnt_q == 2'd2);
		rdata         = mem_q[rd_ptr_q];
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
		end
	end
endmodule
`default_nettype wire

[src/wrlav_back.sv]
// back end: serial mean division and result register
`default_nettype none
module wrlav_back (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      q_empty,
	input  wrlav_pkg::frame_tot_t    q_rdata,
	output logic                     q_pop,
	wrlav_stream_if.source           res
);
	import wrlav_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_HOLD
	} state_t;

	state_t             state_q;
	logic [TOTAL_W-1:0] div_q;
	logic [TOTAL_W-1:0] rem_q;
	logic [RUN_W-1:0]   quo_q;
	logic [3:0]         step_q;
	logic               out_v_q;
	res_t               out_q;

	logic [TOTAL_W:0]   trial;
	logic               qbit;
	logic               load_out;

	assign q_pop     = (state_q == ST_IDLE) && !q_empty;
	assign res.valid = out_v_q;
	assign res.data  = out_q;
	assign load_out  = (state_q == ST_HOLD) && (!out_v_q || res.ready);

	always_comb begin
		trial = {rem_q, quo_q[RUN_W-1]};
		qbit  = (trial >= {1'b0, div_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_v_q <= 1'b0;
			step_q  <= '0;
			div_q   <= '0;
			rem_q   <= '0;
			quo_q   <= '0;
			out_q   <= '0;
		end else begin
			if (load_out) begin
				out_v_q <= 1'b1;
			end else if (res.ready) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						div_q  <= q_rdata.run_total;
						rem_q  <= TOTAL_W'(q_rdata.length_sum[SUM_W-1:RUN_W]);
						quo_q  <= q_rdata.length_sum[RUN_W-1:0];
						step_q <= 4'(RUN_W - 1);
						state_q <= (q_rdata.run_total == '0) ? ST_HOLD : ST_DIV;
					end
				end
				ST_DIV: begin
					rem_q <= qbit ? TOTAL_W'(trial - {1'b0, div_q}) : trial[TOTAL_W-1:0];
					quo_q <= {quo_q[RUN_W-2:0], qbit};
					if (step_q == '0) begin
						state_q <= ST_HOLD;
					end else begin
						step_q <= step_q - 4'd1;
					end
				end
				ST_HOLD: begin
					if (load_out) begin
						if (div_q == '0) begin
							out_q.mean_size    <= '0;
							out_q.runs_counted <= '0;
							out_q.no_runs      <= 1'b1;
						end else begin
							out_q.mean_size    <= quo_q;
							out_q.runs_counted <= div_q;
							out_q.no_runs      <= 1'b0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

[src/window_run_length_averager_unit.sv]
// pixel path: brightness in s1, level in s2, both registered; then classified and counted
// throughput: one pixel per cycle; input stalls only when a frame end finds the two-entry queue full
// result: the back end pops the frame totals and runs the 13-step serial divider
// (skipped when no run was counted); it pops no new frame before the result is loaded
// reset: registers return to their reset values, run state and queue cleared at once
`default_nettype none
module window_run_length_averager_unit #(
	parameter int MAX_ROW_WIDTH = 4096
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     cfg_we,
	input  wrlav_pkg::cfg_idx_t     cfg_idx,
	input  wire [15:0]              cfg_wdata,
	wrlav_stream_if.sink            pix,
	wrlav_stream_if.source          res
);
	import wrlav_pkg::*;

	cfg_t       cfg_q;
	q_ctl_t     q_req, q_st;
	frame_tot_t q_wdata, q_rdata;
	logic       q_push, q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.level_low  <= 16'd128;
			cfg_q.level_high <= 16'd255;
			cfg_q.min_run    <= '0;
			cfg_q.color_mode <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_LEVEL_LOW:  cfg_q.level_low  <= cfg_wdata;
				REG_LEVEL_HIGH: cfg_q.level_high <= cfg_wdata;
				REG_MIN_RUN:    cfg_q.min_run    <= cfg_wdata[RUN_W-1:0];
				REG_COLOR_MODE: cfg_q.color_mode <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		q_req.push  = q_push;
		q_req.pop   = q_pop;
		q_req.empty = 1'b0;
		q_req.full  = 1'b0;
	end

	wrlav_front #(
		.MAX_ROW_WIDTH(MAX_ROW_WIDTH)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.pix     (pix),
		.q_full  (q_st.full),
		.q_push  (q_push),
		.q_wdata (q_wdata)
	);

	wrlav_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl_in  (q_req),
		.wdata   (q_wdata),
		.ctl_out (q_st),
		.rdata   (q_rdata)
	);

	wrlav_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_st.empty),
		.q_rdata (q_rdata),
		.q_pop   (q_pop),
		.res     (res)
	);
endmodule
`default_nettype wire
